/* hdl/fmi_pkg.sv */
// ----------------------------------------------------------------------------
// fmi_pkg
// Shared widths, register codes, lane/merge structs and the binomial table
// generator for the folded multi-index unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmi_pkg;

   localparam int IDX_FIELDS = 6;
   localparam int IDX_W      = 4;
   localparam int INC_W      = IDX_W + 1;
   localparam int ORD_W      = 3;
   localparam int OFS_W      = 16;
   localparam int NV_W       = 4;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 32;

   localparam logic [CSR_AW-1:0] REG_NUM_VARS = CSR_AW'(0);
   localparam logic [NV_W-1:0]   NUM_VARS_RST = NV_W'(15);
   localparam logic [IDX_W-1:0]  IDX_MAX      = '1;

   localparam logic REQ_OFFSET = 1'b0;
   localparam logic REQ_NEXT   = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [OFS_W-1:0] term;
      idx_type          raw;
      logic             ovf;
   } lane_out_type;

   typedef struct packed {
      logic             next_mode;
      logic [ORD_W-1:0] order;
   } item_ctrl_type;

   // Pascal's triangle, kept modulo 2^OFS_W; used at elaboration only
   function automatic logic [OFS_W-1:0] binom(input int a, input int b);
      logic [OFS_W-1:0] row [IDX_FIELDS+1];
      for (int c = 0; c <= IDX_FIELDS; c++) begin
         row[c] = (c == 0) ? OFS_W'(1) : '0;
      end
      for (int r = 0; r < a; r++) begin
         for (int c = IDX_FIELDS; c > 0; c--) begin
            row[c] = row[c] + row[c-1];
         end
      end
      return (b >= 0 && b <= IDX_FIELDS) ? row[b] : '0;
   endfunction

endpackage

`default_nettype wire

/* hdl/fmi_lane.sv */
// ----------------------------------------------------------------------------
// fmi_lane
// One index position: folded-offset term from the binomial table and the
// increment/overflow flag for the carry chain. Output is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmi_lane import fmi_pkg::*; #(
   parameter int MAX_VARS = 15,
   parameter int LANES    = 6,
   localparam int NW      = $clog2(MAX_VARS + 1),
   localparam int LW      = $clog2(LANES + 1)
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic          active,
   input  wire logic [NW-1:0] n,
   input  wire logic [NW-1:0] prev,
   input  wire logic [NW-1:0] cur,
   input  wire logic [LW-1:0] len,
   input  wire idx_type       raw,
   output lane_out_type       lane_out
);

   localparam int ROWS = MAX_VARS + LANES;
   localparam int COLS = LANES + 1;
   localparam int AW   = $clog2(ROWS);

   logic [OFS_W-1:0] rom [ROWS][COLS];
   logic [AW-1:0]    hi_row;
   logic [AW-1:0]    lo_row;
   logic [INC_W-1:0] inc;
   lane_out_type     lane_in;
   lane_out_type     lane_ff;

   for (genvar a = 0; a < ROWS; a++) begin : g_row
      for (genvar b = 0; b < COLS; b++) begin : g_col
         assign rom[a][b] = binom(a, b);
      end
   end

   assign hi_row = AW'(n) - AW'(prev) + AW'(len) - AW'(1);
   assign lo_row = AW'(n) - AW'(cur) + AW'(len) - AW'(1);
   assign inc    = INC_W'(raw) + INC_W'(1);

   always_comb begin
      lane_in.term = active ? (rom[hi_row][len] - rom[lo_row][len]) : '0;
      lane_in.raw  = raw;
      lane_in.ovf  = (inc >= INC_W'(n));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

/* hdl/fmi_merge.sv */
// ----------------------------------------------------------------------------
// fmi_merge
// Combines the lane results: sums the offset terms, runs the carry chain and
// the monotone fill for the next index, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmi_merge import fmi_pkg::*; #(
   parameter int LANES = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire logic          valid_in,
   input  wire item_ctrl_type ctrl,
   input  wire lane_out_type  lanes [LANES],
   output logic               out_valid,
   output logic [OFS_W-1:0]   offset,
   output idx_type            next [IDX_FIELDS]
);

   logic             valid_ff;
   logic [OFS_W-1:0] offset_in;
   logic [OFS_W-1:0] offset_ff;
   idx_type          next_in [IDX_FIELDS];
   idx_type          next_ff [IDX_FIELDS];

   always_comb begin
      logic [OFS_W-1:0] sum;
      logic [LANES-1:0] carry;
      logic             cin;
      logic             pass;
      logic [INC_W-1:0] inc;
      idx_type          v;
      idx_type          run_max;

      sum = '0;
      for (int j = 0; j < LANES; j++) begin
         sum = sum + lanes[j].term;
      end

      // carry ripples from the last valid position toward the first
      pass = 1'b0;
      for (int j = LANES - 1; j >= 0; j--) begin
         if (j + 1 == int'(ctrl.order)) begin
            cin = 1'b1;
         end else if (j + 1 < int'(ctrl.order)) begin
            cin = pass;
         end else begin
            cin = 1'b0;
         end
         carry[j] = cin;
         pass     = cin & lanes[j].ovf;
      end

      run_max = '0;
      for (int j = 0; j < IDX_FIELDS; j++) begin
         next_in[j] = '0;
      end
      for (int j = 0; j < LANES; j++) begin
         inc = INC_W'(lanes[j].raw) + INC_W'(1);
         if (!carry[j]) begin
            v = lanes[j].raw;
         end else if (j == 0) begin
            v = (inc > INC_W'(IDX_MAX)) ? IDX_MAX : inc[IDX_W-1:0];
         end else begin
            v = lanes[j].ovf ? '0 : inc[IDX_W-1:0];
         end
         if (v < run_max) begin
            v = run_max;
         end
         run_max = v;
         if (ctrl.next_mode == REQ_NEXT && j < int'(ctrl.order)) begin
            next_in[j] = v;
         end
      end

      offset_in = (ctrl.next_mode == REQ_OFFSET) ? sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         offset_ff <= offset_in;
         next_ff   <= next_in;
      end
   end

   assign out_valid = valid_ff;
   assign offset    = offset_ff;
   assign next      = next_ff;

endmodule

`default_nettype wire

/* hdl/folded_multi_index_unit.sv */
// ----------------------------------------------------------------------------
// folded_multi_index_unit
// Folded (symmetric) tensor multi-index unit: offset and next-index modes.
//
// Request channel (req_*): one nondecreasing multi-index per transfer with
// its order and mode. req_type low asks for the position of the index in
// folded storage, high asks for the next folded index.
// Response channel (rsp_*): one result per request, in order. Offset mode
// returns rsp_folded_offset with zero next fields; next mode returns
// rsp_next_* with zero offset. A first position equal to num_vars means
// past the end.
// CSR port (csr_*): num_vars at byte address 0, written only while idle by the
// user; the block does not enforce this. A request passes the input register,
// the lane stage (table lookup per position) and the merge stage (term sum,
// carry chain, output register). Throughput is one item per cycle unless the
// response stalls; each position has its own lane, so order does not change
// timing. Reset empties the pipeline and sets num_vars to 15. A stalled
// response holds; earlier stages keep filling until full, then req_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module folded_multi_index_unit import fmi_pkg::*; #(
   parameter int ORDER_LIMIT = 6,
   parameter int MAX_VARS    = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire logic [ORD_W-1:0]  req_index_order,
   input  wire idx_type           req_idx_0,
   input  wire idx_type           req_idx_1,
   input  wire idx_type           req_idx_2,
   input  wire idx_type           req_idx_3,
   input  wire idx_type           req_idx_4,
   input  wire idx_type           req_idx_5,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [OFS_W-1:0]       rsp_folded_offset,
   output idx_type                rsp_next_0,
   output idx_type                rsp_next_1,
   output idx_type                rsp_next_2,
   output idx_type                rsp_next_3,
   output idx_type                rsp_next_4,
   output idx_type                rsp_next_5,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int LANES = (ORDER_LIMIT < IDX_FIELDS) ? ORDER_LIMIT : IDX_FIELDS;
   localparam int NW    = $clog2(MAX_VARS + 1);
   localparam int LW    = $clog2(LANES + 1);

   logic [NV_W-1:0] num_vars_ff;
   logic [NV_W-1:0] num_vars_in;
   logic            csr_wr;
   logic [NW-1:0]   n_eff;

   logic            en1;
   logic            en2;
   logic            en_out;

   logic            v1_ff;
   item_ctrl_type   ctrl1_in;
   item_ctrl_type   ctrl1_ff;
   idx_type         raw_in [IDX_FIELDS];
   idx_type         raw1_ff [IDX_FIELDS];
   logic [NW-1:0]   clean [LANES];

   logic            v2_ff;
   item_ctrl_type   ctrl2_ff;
   lane_out_type    lane_res [LANES];

   idx_type         next [IDX_FIELDS];

   // ---- configuration
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready &
                        (csr_paddr == REG_NUM_VARS);
   assign num_vars_in = csr_pwdata[NV_W-1:0];
   assign csr_prdata  = (csr_paddr == REG_NUM_VARS) ? CSR_DW'(num_vars_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff <= NUM_VARS_RST;
      end else if (csr_wr) begin
         num_vars_ff <= num_vars_in;
      end
   end

   always_comb begin
      if (num_vars_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(num_vars_ff) > MAX_VARS) begin
         n_eff = NW'(MAX_VARS);
      end else begin
         n_eff = NW'(num_vars_ff);
      end
   end

   // ---- flow control
   assign en_out    = !rsp_valid || !rsp_stall;
   assign en2       = !v2_ff || en_out;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   // ---- input register
   always_comb begin
      ctrl1_in.next_mode = req_type;
      ctrl1_in.order     = (int'(req_index_order) > LANES) ? ORD_W'(LANES)
                                                           : req_index_order;
      raw_in[0] = req_idx_0;
      raw_in[1] = req_idx_1;
      raw_in[2] = req_idx_2;
      raw_in[3] = req_idx_3;
      raw_in[4] = req_idx_4;
      raw_in[5] = req_idx_5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctrl1_ff <= ctrl1_in;
         raw1_ff  <= raw_in;
      end
      if (en2) begin
         ctrl2_ff <= ctrl1_ff;
      end
   end

   // clamp each position to n-1, then make the index nondecreasing
   always_comb begin
      logic [NW-1:0] c;
      logic [NW-1:0] prev;
      prev = '0;
      for (int j = 0; j < LANES; j++) begin
         if (int'(raw1_ff[j]) > int'(n_eff) - 1) begin
            c = n_eff - NW'(1);
         end else begin
            c = NW'(raw1_ff[j]);
         end
         if (c < prev) begin
            c = prev;
         end
         clean[j] = c;
         prev     = c;
      end
   end

   // ---- lanes
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [NW-1:0] lane_prev;
      logic          lane_active;
      logic [LW-1:0] lane_len;

      if (j == 0) begin : g_first
         assign lane_prev = '0;
      end else begin : g_rest
         assign lane_prev = clean[j-1];
      end

      assign lane_active = (j < int'(ctrl1_ff.order));
      assign lane_len    = LW'(ctrl1_ff.order - ORD_W'(j));

      fmi_lane #(
         .MAX_VARS (MAX_VARS),
         .LANES    (LANES)
      ) u_lane (
         .clock    (clock),
         .enable   (en2),
         .active   (lane_active),
         .n        (n_eff),
         .prev     (lane_prev),
         .cur      (clean[j]),
         .len      (lane_len),
         .raw      (raw1_ff[j]),
         .lane_out (lane_res[j])
      );
   end

   // ---- merge and output register
   fmi_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .enable    (en_out),
      .valid_in  (v2_ff),
      .ctrl      (ctrl2_ff),
      .lanes     (lane_res),
      .out_valid (rsp_valid),
      .offset    (rsp_folded_offset),
      .next      (next)
   );

   assign rsp_next_0 = next[0];
   assign rsp_next_1 = next[1];
   assign rsp_next_2 = next[2];
   assign rsp_next_3 = next[3];
   assign rsp_next_4 = next[4];
   assign rsp_next_5 = next[5];

endmodule

`default_nettype wire

/* hdl/fmi_checker.sv */
// ----------------------------------------------------------------------------
// fmi_checker
// Port-level checks for the folded multi-index unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmi_checker import fmi_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              req_type,
   input wire logic [ORD_W-1:0]  req_index_order,
   input wire idx_type           req_idx_0,
   input wire idx_type           req_idx_1,
   input wire idx_type           req_idx_2,
   input wire idx_type           req_idx_3,
   input wire idx_type           req_idx_4,
   input wire idx_type           req_idx_5,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [OFS_W-1:0]  rsp_folded_offset,
   input wire idx_type           rsp_next_0,
   input wire idx_type           rsp_next_1,
   input wire idx_type           rsp_next_2,
   input wire idx_type           rsp_next_3,
   input wire idx_type           rsp_next_4,
   input wire idx_type           rsp_next_5,
   input wire logic              csr_psel,
   input wire logic              csr_penable,
   input wire logic              csr_pwrite,
   input wire logic [CSR_AW-1:0] csr_paddr,
   input wire logic [CSR_DW-1:0] csr_pwdata,
   input wire logic [CSR_DW-1:0] csr_prdata,
   input wire logic              csr_pready
);

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the output register empty the whole pipeline can move
   a_empty_accepts : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // a stalled response transfer holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_folded_offset) &&
         $stable(rsp_next_0) && $stable(rsp_next_1) && $stable(rsp_next_2) &&
         $stable(rsp_next_3) && $stable(rsp_next_4) && $stable(rsp_next_5))
      else $error("stalled response changed");

   // an offset result never carries next-index fields
   a_mode_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_folded_offset != '0 |->
         rsp_next_0 == '0 && rsp_next_1 == '0 && rsp_next_2 == '0 &&
         rsp_next_3 == '0 && rsp_next_4 == '0 && rsp_next_5 == '0)
      else $error("offset and next index both nonzero");

endmodule

bind folded_multi_index_unit fmi_checker u_fmi_checker (.*);

`default_nettype wire
